### hw/rtl/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants of the turtle pen plotter: canvas geometry,
// command, pen and heading codes, and the result of the cell step unit.
// ----------------------------------------------------------------------------
package tpp_pkg;

    // Canvas is CANVAS_SIZE x CANVAS_SIZE cells, with 2 <= CANVAS_SIZE <= 64.
    localparam int CANVAS_SIZE = 64;
    localparam int ROW_W       = 64;
    localparam int POS_W       = 6;
    localparam int ROW_AW      = (CANVAS_SIZE > 1) ? $clog2(CANVAS_SIZE) : 1;
    localparam int STEPS_W     = 7;

    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(CANVAS_SIZE - 1);
    localparam logic [ROW_W-1:0] ROW_MASK = (CANVAS_SIZE >= 64) ? {ROW_W{1'b1}} :
                                            ((ROW_W'(1) << CANVAS_SIZE) - ROW_W'(1));

    typedef enum logic [2:0] {
        KIND_PEN_UP    = 3'd0,
        KIND_PEN_DRAW  = 3'd1,
        KIND_PEN_ERASE = 3'd2,
        KIND_TURN_R    = 3'd3,
        KIND_TURN_L    = 3'd4,
        KIND_MOVE      = 3'd5,
        KIND_DUMP      = 3'd6
    } cmd_kind_t;

    typedef enum logic [1:0] {
        PEN_UP    = 2'd0,
        PEN_DRAW  = 2'd1,
        PEN_ERASE = 2'd2
    } pen_mode_t;

    typedef enum logic [1:0] {
        HEAD_LEFT  = 2'd0,
        HEAD_UP    = 2'd1,
        HEAD_RIGHT = 2'd2,
        HEAD_DOWN  = 2'd3
    } heading_t;

    typedef struct packed {
        logic [POS_W-1:0] next_row;
        logic [POS_W-1:0] next_col;
        logic             at_edge;
    } step_res_t;

endpackage

### hw/rtl/turtle_pen_plotter_unit.sv
// ----------------------------------------------------------------------------
// turtle_pen_plotter_unit
// Turtle-graphics drawing engine over a square one-bit canvas held in RAM.
// ----------------------------------------------------------------------------
// The block takes one command at a time and stalls the command channel until
// the command's work is done. Pen and turn commands, a move of zero steps and
// the unused kind post their status result from the emit state. A move of n
// steps visits up to n cells, with a read and a write of the canvas row in RAM
// for each visited cell, and then posts its status result. A dump first opens
// the read of the first row and then emits one row per cycle while the result
// channel does not stall, CANVAS_SIZE results in all, the last one flagged;
// the result register lets the next command be taken while the final result
// still waits. A stall on the result channel holds the work.
// The canvas is cleared at reset by per-row valid flags, so no clearing pass
// runs and the block is ready right after reset.
// ----------------------------------------------------------------------------
module turtle_pen_plotter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  logic [2:0]                  kind,
    input  logic [tpp_pkg::STEPS_W-1:0] steps,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [tpp_pkg::ROW_W-1:0]   row_bits,
    output logic [tpp_pkg::POS_W-1:0]   row_index,
    output logic                        last,
    output logic [1:0]                  pen_now,
    output logic [1:0]                  heading_now,
    output logic [tpp_pkg::POS_W-1:0]   pos_row_now,
    output logic [tpp_pkg::POS_W-1:0]   pos_col_now
);

    import tpp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_EMIT     = 6'b000010,
        ST_MV_RD    = 6'b000100,
        ST_MV_WR    = 6'b001000,
        ST_DUMP_RD  = 6'b010000,
        ST_DUMP_OUT = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    pen_mode_t           pen_reg, pen_next;
    heading_t            head_reg, head_next;
    logic [POS_W-1:0]    prow_reg, prow_next;
    logic [POS_W-1:0]    pcol_reg, pcol_next;
    logic [STEPS_W-1:0]  remain_reg, remain_next;
    logic [POS_W-1:0]    dump_row_reg, dump_row_next;
    logic [CANVAS_SIZE-1:0] row_vld_reg, row_vld_next;
    logic                rvld_reg;

    logic                res_valid_reg, res_valid_next;
    logic [ROW_W-1:0]    res_bits_reg, res_bits_next;
    logic [POS_W-1:0]    res_row_reg, res_row_next;
    logic                res_last_reg, res_last_next;
    logic [1:0]          res_pen_reg, res_pen_next;
    logic [1:0]          res_head_reg, res_head_next;
    logic [POS_W-1:0]    res_prow_reg, res_prow_next;
    logic [POS_W-1:0]    res_pcol_reg, res_pcol_next;

    logic                accept;
    logic                out_free;
    logic                res_load;
    logic [POS_W-1:0]    rd_row;
    logic [ROW_AW-1:0]   raddr;
    logic [ROW_W-1:0]    rdata;
    logic [ROW_W-1:0]    base_row;
    logic [ROW_W-1:0]    cell_bit;
    logic [ROW_W-1:0]    wdata;
    logic                we;
    step_res_t           step;

    tpp_step u_step (
        .heading (head_reg),
        .pos_row (prow_reg),
        .pos_col (pcol_reg),
        .res     (step)
    );

    tpp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CANVAS_SIZE)
    ) u_canvas (
        .clk   (clk),
        .we    (we),
        .waddr (prow_reg[ROW_AW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign accept   = cmd_valid && (state_reg == ST_IDLE);
    assign out_free = !res_valid_reg || !res_stall;

    // During a dump the next row is addressed as soon as the current one is
    // posted, so rows stream out one per cycle while the result channel does not stall.
    always_comb
    begin
        case (state_reg)
            ST_DUMP_RD:  rd_row = dump_row_reg;
            ST_DUMP_OUT: rd_row = out_free ? (dump_row_reg + POS_W'(1)) : dump_row_reg;
            default:     rd_row = prow_reg;
        endcase
    end

    assign raddr    = rd_row[ROW_AW-1:0];
    assign base_row = rvld_reg ? rdata : '0;
    assign cell_bit = ROW_W'(1) << pcol_reg;
    assign wdata    = (pen_reg == PEN_DRAW) ? (base_row | cell_bit) : (base_row & ~cell_bit);
    assign we       = (state_reg == ST_MV_WR) && (pen_reg != PEN_UP);

    always_comb
    begin
        state_next    = state_reg;
        pen_next      = pen_reg;
        head_next     = head_reg;
        prow_next     = prow_reg;
        pcol_next     = pcol_reg;
        remain_next   = remain_reg;
        dump_row_next = dump_row_reg;
        row_vld_next  = row_vld_reg;
        res_load      = 1'b0;
        res_bits_next = res_bits_reg;
        res_row_next  = res_row_reg;
        res_last_next = res_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EMIT;
                    case (kind)
                        KIND_PEN_UP:    pen_next = PEN_UP;
                        KIND_PEN_DRAW:  pen_next = PEN_DRAW;
                        KIND_PEN_ERASE: pen_next = PEN_ERASE;
                        KIND_TURN_R:    head_next = heading_t'(head_reg + 2'd1);
                        KIND_TURN_L:    head_next = heading_t'(head_reg + 2'd3);
                        KIND_MOVE:
                        begin
                            remain_next = steps;
                            if (steps != '0)
                            begin
                                state_next = ST_MV_RD;
                            end
                        end
                        KIND_DUMP:
                        begin
                            dump_row_next = '0;
                            state_next    = ST_DUMP_RD;
                        end
                        default: state_next = ST_EMIT;
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_load      = 1'b1;
                    res_bits_next = '0;
                    res_row_next  = '0;
                    res_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_MV_RD:
            begin
                state_next = ST_MV_WR;
            end
            ST_MV_WR:
            begin
                if (we)
                begin
                    row_vld_next[prow_reg[ROW_AW-1:0]] = 1'b1;
                end
                remain_next = remain_reg - STEPS_W'(1);
                if ((remain_reg == STEPS_W'(1)) || step.at_edge)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    prow_next  = step.next_row;
                    pcol_next  = step.next_col;
                    state_next = ST_MV_RD;
                end
            end
            ST_DUMP_RD:
            begin
                state_next = ST_DUMP_OUT;
            end
            ST_DUMP_OUT:
            begin
                if (out_free)
                begin
                    res_load      = 1'b1;
                    res_bits_next = base_row & ROW_MASK;
                    res_row_next  = dump_row_reg;
                    res_last_next = (dump_row_reg == POS_MAX);
                    dump_row_next = dump_row_reg + POS_W'(1);
                    if (dump_row_reg == POS_MAX)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign res_pen_next  = pen_reg;
    assign res_head_next = head_reg;
    assign res_prow_next = prow_reg;
    assign res_pcol_next = pcol_reg;

    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_stall)
        begin
            res_valid_next = res_valid_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pen_reg       <= PEN_UP;
            head_reg      <= HEAD_RIGHT;
            prow_reg      <= '0;
            pcol_reg      <= '0;
            remain_reg    <= '0;
            dump_row_reg  <= '0;
            row_vld_reg   <= '0;
            rvld_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pen_reg       <= pen_next;
            head_reg      <= head_next;
            prow_reg      <= prow_next;
            pcol_reg      <= pcol_next;
            remain_reg    <= remain_next;
            dump_row_reg  <= dump_row_next;
            row_vld_reg   <= row_vld_next;
            rvld_reg      <= row_vld_reg[raddr];
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_bits_reg <= res_bits_next;
            res_row_reg  <= res_row_next;
            res_last_reg <= res_last_next;
            res_pen_reg  <= res_pen_next;
            res_head_reg <= res_head_next;
            res_prow_reg <= res_prow_next;
            res_pcol_reg <= res_pcol_next;
        end
    end

    assign cmd_stall   = (state_reg != ST_IDLE);
    assign res_valid   = res_valid_reg;
    assign row_bits    = res_bits_reg;
    assign row_index   = res_row_reg;
    assign last        = res_last_reg;
    assign pen_now     = res_pen_reg;
    assign heading_now = res_head_reg;
    assign pos_row_now = res_prow_reg;
    assign pos_col_now = res_pcol_reg;

    // The turtle never leaves the canvas.
    a_pos_on_canvas: assert property (@(posedge clk) disable iff (!rst_n)
        (prow_reg <= POS_MAX) && (pcol_reg <= POS_MAX))
        else $error("turtle position outside the canvas");

    // Only dump rows may go out without the last flag.
    a_not_last_only_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && !res_last_next) |-> (state_reg == ST_DUMP_OUT))
        else $error("result without last flag outside a dump");

    // A move with nonzero steps always visits the current cell first.
    a_move_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_MOVE) && (steps != '0)) |=> (state_reg == ST_MV_RD))
        else $error("move did not start with a row read");

    // Posting the last dump row frees the command channel.
    a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DUMP_OUT) && res_load && (dump_row_reg == POS_MAX))
        |=> (state_reg == ST_IDLE))
        else $error("dump did not finish after the last row");

    // The pen mode never takes the unused code.
    a_pen_code: assert property (@(posedge clk) disable iff (!rst_n)
        (pen_reg == PEN_UP) || (pen_reg == PEN_DRAW) || (pen_reg == PEN_ERASE))
        else $error("pen mode holds an unused code");

endmodule

### hw/rtl/tpp_ram.sv
// ----------------------------------------------------------------------------
// tpp_ram
// Generic RAM: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tpp_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/tpp_step.sv
// ----------------------------------------------------------------------------
// tpp_step
// Cell step unit: next position one cell along the heading, and whether
// the turtle already stands on the canvas edge in that direction.
// ----------------------------------------------------------------------------
module tpp_step (
    input  tpp_pkg::heading_t         heading,
    input  logic [tpp_pkg::POS_W-1:0] pos_row,
    input  logic [tpp_pkg::POS_W-1:0] pos_col,
    output tpp_pkg::step_res_t        res
);

    import tpp_pkg::*;

    logic             vertical;
    logic             down_dir;
    logic [POS_W-1:0] cur;
    logic [POS_W-1:0] moved;
    logic             edge_hit;

    always_comb
    begin
        vertical = heading[0];
        // Left and up count the coordinate down; right and down count it up.
        down_dir = (heading == HEAD_LEFT) || (heading == HEAD_UP);
        cur      = vertical ? pos_row : pos_col;
        if (down_dir)
        begin
            edge_hit = (cur == '0);
            moved    = cur - POS_W'(1);
        end
        else
        begin
            edge_hit = (cur >= POS_MAX);
            moved    = cur + POS_W'(1);
        end
        res.at_edge  = edge_hit;
        res.next_row = vertical ? moved : pos_row;
        res.next_col = vertical ? pos_col : moved;
    end

endmodule
